// ===== src/atfb_pkg.sv =====
// ----------------------------------------------------------------------------
// atfb_pkg
// Shared constants for the API transmit-request frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package atfb_pkg;

   // frame geometry
   localparam int PAYLOAD_BYTES = 64;
   localparam int IDX_W         = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PAYLOAD_BYTES - 1);
   localparam logic [15:0] FRAME_LEN = 16'(PAYLOAD_BYTES + 14);

   // fixed header bytes
   localparam logic [7:0] DELIM_BYTE    = 8'h7E;
   localparam logic [7:0] TYPE_TX_REQ   = 8'h10;
   localparam logic [7:0] NET_ADDR_HI   = 8'hFF;
   localparam logic [7:0] NET_ADDR_LO   = 8'hFE;
   localparam logic [7:0] FRAME_ID_INIT = 8'h01;
   localparam logic [7:0] OPTIONS_INIT  = 8'hC0;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_ADDRESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TX_OPTIONS   = 2'd2;

   // emit positions within one frame
   localparam int POS_W = 5;
   localparam logic [POS_W-1:0] POS_DELIM    = 5'd0;
   localparam logic [POS_W-1:0] POS_LEN_HI   = 5'd1;
   localparam logic [POS_W-1:0] POS_LEN_LO   = 5'd2;
   localparam logic [POS_W-1:0] POS_TYPE     = 5'd3;
   localparam logic [POS_W-1:0] POS_FRAME_ID = 5'd4;
   localparam logic [POS_W-1:0] POS_DEST_7   = 5'd5;
   localparam logic [POS_W-1:0] POS_DEST_0   = 5'd12;
   localparam logic [POS_W-1:0] POS_NET_HI   = 5'd13;
   localparam logic [POS_W-1:0] POS_NET_LO   = 5'd14;
   localparam logic [POS_W-1:0] POS_RADIUS   = 5'd15;
   localparam logic [POS_W-1:0] POS_OPTIONS  = 5'd16;
   localparam logic [POS_W-1:0] POS_PAYLOAD  = 5'd17;
   localparam logic [POS_W-1:0] POS_CHECKSUM = 5'd18;

endpackage : atfb_pkg

`default_nettype wire

// ===== src/api_tx_frame_builder_core.sv =====
// ----------------------------------------------------------------------------
// api_tx_frame_builder_core
// Wraps each group of payload bytes in an API transmit-request frame.
// ----------------------------------------------------------------------------
// The first byte caused by an input passes the input stage and then the output register.
// Throughput: one output byte per cycle while rsp_stall is low, set by the single
//   output byte lane; the first byte of a frame is preceded by the header, and the
//   last byte of a frame is followed by the checksum.
// Reset: synchronous; clears the pipeline, sets frame id to 1, index and sum to
//   0, and loads the configuration registers with their reset values.
`default_nettype none

module api_tx_frame_builder_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // configuration write port
   input  wire logic                           csr_we,
   input  wire logic [atfb_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [63:0]                    csr_wdata,
   // payload input
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [7:0]                     req_payload_byte,
   // framed output
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [7:0]                          rsp_tx_byte,
   output logic                                rsp_last_of_run,
   output logic                                rsp_frame_end
);
   import atfb_pkg::*;

   // configuration registers
   logic [63:0] dest_ff;
   logic [7:0]  radius_ff;
   logic [7:0]  options_ff;

   // frame state
   logic [7:0]       frame_id_ff, frame_id_in;
   logic [IDX_W-1:0] index_ff, index_in;
   logic [7:0]       sum_ff, sum_in;

   // input stage
   logic             cur_valid_ff, cur_valid_in;
   logic [7:0]       cur_byte_ff;
   logic             cur_last_ff;
   logic [POS_W-1:0] cur_pos_ff, cur_pos_in;

   // output register
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff;
   logic       out_last_ff;
   logic       out_end_ff;

   logic       out_load;
   logic       emit;
   logic       emit_done;
   logic       req_take;
   logic [7:0] emit_byte;
   logic [2:0] dest_sel;
   logic [7:0] dest_byte;

   // handshake
   assign out_load  = !out_valid_ff || !rsp_stall;
   assign emit      = cur_valid_ff && out_load;
   assign emit_done = (cur_pos_ff == POS_CHECKSUM) ||
                      ((cur_pos_ff == POS_PAYLOAD) && !cur_last_ff);
   assign req_stall = cur_valid_ff && !(emit && emit_done);
   assign req_take  = req_valid && !req_stall;

   // destination address byte, most significant first
   assign dest_sel  = 3'(POS_DEST_0 - cur_pos_ff);
   assign dest_byte = dest_ff[{dest_sel, 3'b000} +: 8];

   // select the byte for the current position
   always_comb begin
      case (cur_pos_ff)
         POS_DELIM:    emit_byte = DELIM_BYTE;
         POS_LEN_HI:   emit_byte = FRAME_LEN[15:8];
         POS_LEN_LO:   emit_byte = FRAME_LEN[7:0];
         POS_TYPE:     emit_byte = TYPE_TX_REQ;
         POS_FRAME_ID: emit_byte = frame_id_ff;
         POS_NET_HI:   emit_byte = NET_ADDR_HI;
         POS_NET_LO:   emit_byte = NET_ADDR_LO;
         POS_RADIUS:   emit_byte = radius_ff;
         POS_OPTIONS:  emit_byte = options_ff;
         POS_PAYLOAD:  emit_byte = cur_byte_ff;
         POS_CHECKSUM: emit_byte = ~sum_ff;
         default:      emit_byte = dest_byte;
      endcase
   end

   // advance the input stage and the frame state
   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_pos_in   = cur_pos_ff;
      index_in     = index_ff;
      frame_id_in  = frame_id_ff;
      sum_in       = sum_ff;

      if (emit) begin
         if (emit_done) begin
            cur_valid_in = 1'b0;
         end else if (cur_pos_ff == POS_PAYLOAD) begin
            cur_pos_in = POS_CHECKSUM;
         end else begin
            cur_pos_in = cur_pos_ff + POS_W'(1);
         end
         // running sum from the type byte through the last payload byte
         if (cur_pos_ff == POS_TYPE) begin
            sum_in = emit_byte;
         end else if (cur_pos_ff inside {[POS_FRAME_ID:POS_PAYLOAD]}) begin
            sum_in = sum_ff + emit_byte;
         end
         if (cur_pos_ff == POS_CHECKSUM) begin
            frame_id_in = frame_id_ff + 8'd1;
         end
      end

      if (req_take) begin
         cur_valid_in = 1'b1;
         cur_pos_in   = (index_ff == '0) ? POS_DELIM : POS_PAYLOAD;
         index_in     = (index_ff == IDX_LAST) ? '0 : index_ff + IDX_W'(1);
      end
   end

   assign out_valid_in = out_load ? cur_valid_ff : out_valid_ff;

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         cur_pos_ff   <= POS_DELIM;
         out_valid_ff <= 1'b0;
         index_ff     <= '0;
         frame_id_ff  <= FRAME_ID_INIT;
         sum_ff       <= 8'd0;
         dest_ff      <= 64'd0;
         radius_ff    <= 8'd0;
         options_ff   <= OPTIONS_INIT;
      end else begin
         cur_valid_ff <= cur_valid_in;
         cur_pos_ff   <= cur_pos_in;
         out_valid_ff <= out_valid_in;
         index_ff     <= index_in;
         frame_id_ff  <= frame_id_in;
         sum_ff       <= sum_in;
         if (csr_we) begin
            case (csr_index)
               CSR_DEST_ADDRESS: dest_ff    <= csr_wdata;
               CSR_RADIUS:       radius_ff  <= csr_wdata[7:0];
               CSR_TX_OPTIONS:   options_ff <= csr_wdata[7:0];
               default:          ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         cur_byte_ff <= req_payload_byte;
         cur_last_ff <= (index_ff == IDX_LAST);
      end
      if (emit) begin
         out_byte_ff <= emit_byte;
         out_last_ff <= emit_done;
         out_end_ff  <= (cur_pos_ff == POS_CHECKSUM);
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_tx_byte     = out_byte_ff;
   assign rsp_last_of_run = out_last_ff;
   assign rsp_frame_end   = out_end_ff;

endmodule : api_tx_frame_builder_core

`default_nettype wire

// ===== src/atfb_checker.sv =====
// ----------------------------------------------------------------------------
// atfb_checker
// Port-level checks for the frame builder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module atfb_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_tx_byte,
   input wire logic       rsp_last_of_run,
   input wire logic       rsp_frame_end
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tx_byte) &&
         $stable(rsp_last_of_run) && $stable(rsp_frame_end))
      else $error("stalled result changed");

   // a checksum always closes the run of its input byte
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_last_of_run)
      else $error("frame end without last of run");

   // reset empties both stages
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // a checksum is never followed directly by another checksum
   a_end_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_frame_end |=> !(rsp_valid && rsp_frame_end))
      else $error("back-to-back checksums");

endmodule : atfb_checker

bind api_tx_frame_builder_core atfb_checker u_atfb_checker (.*);

`default_nettype wire
